// ===== rtl/core/dgld_pkg.sv =====
// Package for the diagonal Gaussian log-density block.
// Holds shared constants, the element queue entry type and the back-end state enum.
`default_nettype none
package dgld_pkg;
  localparam int MAX_ELEMENTS_DEF = 4096;
  localparam int QDEPTH = 2;
  localparam logic [63:0] LN2PI_Q32 = 64'd7893621894;
  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;
  localparam int LOG_FRAC_BITS = 40;

  typedef struct packed {
    logic [32:0] diff_mag;
    logic [31:0] variance;
    logic        last;
  } elem_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_LOGNORM, S_LOGSQ, S_LNMUL, S_ACC, S_FIN
  } bstate_t;
endpackage
`default_nettype wire

// ===== rtl/core/dgld_front.sv =====
// Front end: accepts input items, forms |x - mu| and pushes entries into a small FIFO.
// Depends on dgld_pkg.
`default_nettype none
module dgld_front (
  input  wire  logic             clk,
  input  wire  logic             rst,
  input  wire  logic             zero_mean,
  input  wire  logic             in_valid,
  output logic                   in_stall,
  input  wire  logic [31:0]      sample_value,
  input  wire  logic [31:0]      mean_value,
  input  wire  logic [31:0]      variance_value,
  input  wire  logic             last,
  output logic                   q_valid,
  output dgld_pkg::elem_t        q_data,
  input  wire  logic             q_pop
);
  dgld_pkg::elem_t mem [dgld_pkg::QDEPTH];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push;
  logic signed [32:0] d;
  logic signed [31:0] mu;

  assign in_stall = (count == 2'(dgld_pkg::QDEPTH));
  assign push = in_valid && !in_stall;
  assign q_valid = (count != 2'd0);
  assign q_data = mem[rd_ptr];
  assign mu = zero_mean ? 32'sd0 : $signed(mean_value);
  assign d = 33'($signed(sample_value)) - 33'(mu);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr].diff_mag <= d[32] ? 33'(-d) : 33'(d);
      mem[wr_ptr].variance <= variance_value;
      mem[wr_ptr].last <= last;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/dgld_back.sv =====
// Back end: per element a serial divider and a serial log2, then accumulation and result.
// Depends on dgld_pkg.
`default_nettype none
module dgld_back #(
  parameter int MAX_ELEMENTS = dgld_pkg::MAX_ELEMENTS_DEF
) (
  input  wire  logic             clk,
  input  wire  logic             rst,
  input  wire  logic             q_valid,
  input  wire  dgld_pkg::elem_t  q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire  logic             out_stall,
  output logic [63:0]            log_density,
  output logic                   status
);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] CMAX = CW'(MAX_ELEMENTS);
  localparam logic [31:0] LN2_LO = 32'(dgld_pkg::LN2_Q64);
  localparam logic [31:0] LN2_HI = 32'(dgld_pkg::LN2_Q64 >> 32);

  dgld_pkg::bstate_t state, state_next;
  dgld_pkg::elem_t cur;
  logic signed [63:0] quad_sum, log_det_sum, qterm, lterm, total;
  logic [CW-1:0] element_count;
  logic bad_variance;
  logic [81:0] dividend;
  logic [64:0] rem;
  logic [63:0] quo;
  logic qsat;
  logic [6:0] step;
  logic [31:0] m;
  logic [39:0] frac;
  logic [4:0] kpos;
  logic [63:0] mag;
  logic [127:0] prod;
  logic [127:0] part_sh;
  logic [64:0] rem_sh;
  logic [63:0] sq;
  logic signed [63:0] l2;
  logic out_load;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] r;
    r = a + b;
    if (!a[63] && !b[63] && r[63]) return 64'h7FFFFFFFFFFFFFFF;
    if (a[63] && b[63] && !r[63]) return 64'h8000000000000000;
    return r;
  endfunction

  function automatic logic [32:0] q_data_div(logic [31:0] v);
    return {v, 1'b0};
  endfunction

  function automatic logic signed [63:0] total_w();
    return sat_add($signed(64'(element_count) * dgld_pkg::LN2PI_Q32),
                   sat_add(log_det_sum, quad_sum));
  endfunction

  function automatic logic [63:0] total_half(logic signed [63:0] t);
    logic [63:0] tm, h;
    tm = t[63] ? 64'(-t) : 64'(t);
    h = 64'((65'(tm) + 65'd1) >> 1);
    return t[63] ? h : 64'(-h);
  endfunction

  // next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      dgld_pkg::S_IDLE:    if (q_valid) state_next = dgld_pkg::S_DIV;
      dgld_pkg::S_DIV:     if (cur.variance == 32'd0) state_next = dgld_pkg::S_ACC;
                           else if (step == 7'd0) state_next = dgld_pkg::S_LOGNORM;
      dgld_pkg::S_LOGNORM: if (m[31]) state_next = dgld_pkg::S_LOGSQ;
      dgld_pkg::S_LOGSQ:   if (step == 7'd0) state_next = dgld_pkg::S_LNMUL;
      dgld_pkg::S_LNMUL:   if (step == 7'd4) state_next = dgld_pkg::S_ACC;
      dgld_pkg::S_ACC:     state_next = cur.last ? dgld_pkg::S_FIN : dgld_pkg::S_IDLE;
      dgld_pkg::S_FIN:     if (out_load) state_next = dgld_pkg::S_IDLE;
      default:             state_next = dgld_pkg::S_IDLE;
    endcase
  end

  // output logic
  always_comb begin
    q_pop = (state == dgld_pkg::S_IDLE) && q_valid;
    out_load = (state == dgld_pkg::S_FIN) && (!out_valid || !out_stall);
  end

  assign rem_sh = {rem[63:0], dividend[81]};
  assign sq = 64'(m) * 64'(m);
  assign l2 = ($signed(64'(kpos)) - 64'sd16) * 64'sd1099511627776 + $signed(64'(frac));
  assign mag = l2[63] ? 64'(-l2) : 64'(l2);

  // one 32x32 partial product of |l2| * ln2 per cycle
  always_comb begin
    unique case (step[1:0])
      2'd0: part_sh = {64'd0, 64'(mag[31:0]) * 64'(LN2_LO)};
      2'd1: part_sh = {32'd0, 64'(mag[31:0]) * 64'(LN2_HI), 32'd0};
      2'd2: part_sh = {32'd0, 64'(mag[63:32]) * 64'(LN2_LO), 32'd0};
      2'd3: part_sh = {64'(mag[63:32]) * 64'(LN2_HI), 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= dgld_pkg::S_IDLE;
    else state <= state_next;

    unique case (state)
      dgld_pkg::S_IDLE: if (q_valid) begin
        cur <= q_data;
        // (d^2 << 17) + v, 82 bits
        dividend <= ({16'd0, 66'(q_data.diff_mag) * 66'(q_data.diff_mag)} << 17)
                    + 82'(q_data.variance);
        rem <= '0; quo <= '0; qsat <= 1'b0; step <= 7'd81;
        m <= q_data.variance; kpos <= 5'd31; frac <= '0; prod <= '0;
      end
      dgld_pkg::S_DIV: begin
        // restoring division by 2v, one quotient bit per cycle
        if (quo[63:62] != 2'b00) qsat <= 1'b1;
        if (rem_sh >= {32'd0, q_data_div(cur.variance)}) begin
          rem <= rem_sh - {32'd0, q_data_div(cur.variance)};
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[62:0], 1'b0};
        end
        dividend <= {dividend[80:0], 1'b0};
        if (step != 7'd0) step <= step - 7'd1;
        else step <= 7'(dgld_pkg::LOG_FRAC_BITS - 1);
      end
      dgld_pkg::S_LOGNORM: begin
        // normalize mantissa one bit per cycle
        if (!m[31]) begin
          m <= {m[30:0], 1'b0};
          kpos <= kpos - 5'd1;
        end
      end
      dgld_pkg::S_LOGSQ: begin
        frac <= {frac[38:0], sq[63]};
        m <= sq[63] ? sq[63:32] : sq[62:31];
        if (step != 7'd0) step <= step - 7'd1;
      end
      dgld_pkg::S_LNMUL: begin
        if (step != 7'd4) begin
          prod <= prod + part_sh;
          step <= step + 7'd1;
        end else begin
          qterm <= (qsat || quo[63]) ? 64'h7FFFFFFFFFFFFFFF : quo;
          lterm <= l2[63] ? -$signed(64'((prod[127:64] + 64'd128) >> 8))
                          : $signed(64'((prod[127:64] + 64'd128) >> 8));
        end
      end
      default: ;
    endcase

    if (rst || out_load) begin
      quad_sum <= '0; log_det_sum <= '0; element_count <= '0; bad_variance <= 1'b0;
    end else if (state == dgld_pkg::S_ACC) begin
      if (cur.variance == 32'd0) begin
        bad_variance <= 1'b1;
      end else begin
        quad_sum <= sat_add(quad_sum, qterm);
        log_det_sum <= sat_add(log_det_sum, lterm);
      end
      if (element_count < CMAX) element_count <= element_count + CW'(1);
    end

    // result register: load when free or being taken, drop on transfer
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (out_load) begin
      total <= total_w();
      status <= bad_variance;
    end
  end

  assign log_density = status ? 64'd0 : total_half(total);
endmodule
`default_nettype wire

// ===== rtl/core/diagonal_gaussian_log_density.sv =====
// Diagonal Gaussian log-density, one element per item.
// Back end per element: 1 take, 82 divide steps, 1 to 32 normalize steps,
// 40 log squarings, 5 ln multiply, 1 accumulate; zero variance goes from divide to accumulate.
// Result is loaded into its own register from the FIN state and held there;
// the back end takes a new element only when idle; input stalls once the 2-entry queue fills.
// Synchronous reset clears sums, count, error flag, result valid and zero_mean.
`default_nettype none
module diagonal_gaussian_log_density #(
  parameter int MAX_ELEMENTS = dgld_pkg::MAX_ELEMENTS_DEF
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        cfg_valid,
  output logic              cfg_ready,
  input  wire  logic        cfg_data,
  input  wire  logic        in_valid,
  output logic              in_stall,
  input  wire  logic [31:0] sample_value,
  input  wire  logic [31:0] mean_value,
  input  wire  logic [31:0] variance_value,
  input  wire  logic        last,
  output logic              out_valid,
  input  wire  logic        out_stall,
  output logic [63:0]       log_density,
  output logic              status
);
  logic zero_mean;
  logic q_valid, q_pop;
  dgld_pkg::elem_t q_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) zero_mean <= 1'b0;
    else if (cfg_valid) zero_mean <= cfg_data;
  end

  dgld_front u_front (
    .clk, .rst, .zero_mean, .in_valid, .in_stall, .sample_value, .mean_value,
    .variance_value, .last, .q_valid, .q_data, .q_pop
  );

  dgld_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
    .clk, .rst, .q_valid, .q_data, .q_pop, .out_valid, .out_stall, .log_density, .status
  );

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(log_density) && $stable(status))
    else $error("result changed while held");
endmodule
`default_nettype wire
